/* src/t2u_pkg.sv */
`timescale 1ns / 1ps

package t2u_pkg;

    localparam logic [2:0] MODE_PASS    = 3'd0;
    localparam logic [2:0] MODE_UTF16LE = 3'd1;
    localparam logic [2:0] MODE_UTF16BE = 3'd2;
    localparam logic [2:0] MODE_CP1252  = 3'd3;
    localparam logic [2:0] MODE_LATIN1  = 3'd4;

    localparam int MAX_BYTES = 6;

    typedef struct packed {
        logic [7:0]  held_byte;
        logic        held_valid;
        logic [15:0] pend_unit;
        logic        pend_valid;
    } t2u_state_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
    } t2u_expand_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } utf8_seq_t;

    function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
        logic [15:0] cp;
        case (idx)
            5'd0:    cp = 16'h20AC;
            5'd1:    cp = 16'h0081;
            5'd2:    cp = 16'h201A;
            5'd3:    cp = 16'h0192;
            5'd4:    cp = 16'h201E;
            5'd5:    cp = 16'h2026;
            5'd6:    cp = 16'h2020;
            5'd7:    cp = 16'h2021;
            5'd8:    cp = 16'h02C6;
            5'd9:    cp = 16'h2030;
            5'd10:   cp = 16'h0160;
            5'd11:   cp = 16'h2039;
            5'd12:   cp = 16'h0152;
            5'd13:   cp = 16'h008D;
            5'd14:   cp = 16'h017D;
            5'd15:   cp = 16'h008F;
            5'd16:   cp = 16'h0090;
            5'd17:   cp = 16'h2018;
            5'd18:   cp = 16'h2019;
            5'd19:   cp = 16'h201C;
            5'd20:   cp = 16'h201D;
            5'd21:   cp = 16'h2022;
            5'd22:   cp = 16'h2013;
            5'd23:   cp = 16'h2014;
            5'd24:   cp = 16'h02DC;
            5'd25:   cp = 16'h2122;
            5'd26:   cp = 16'h0161;
            5'd27:   cp = 16'h203A;
            5'd28:   cp = 16'h0153;
            5'd29:   cp = 16'h009D;
            5'd30:   cp = 16'h017E;
            5'd31:   cp = 16'h0178;
            default: cp = 16'h0000;
        endcase
        return cp;
    endfunction

    // code points above 0x10FFFF cannot arise here
    function automatic utf8_seq_t utf8_encode(input logic [20:0] cp, input logic en);
        utf8_seq_t s;
        s = '0;
        if (cp[20:7] == '0)
        begin
            s.b[0] = {1'b0, cp[6:0]};
            s.n    = 3'd1;
        end
        else if (cp[20:11] == '0)
        begin
            s.b[0] = {3'b110, cp[10:6]};
            s.b[1] = {2'b10, cp[5:0]};
            s.n    = 3'd2;
        end
        else if (cp[20:16] == '0)
        begin
            s.b[0] = {4'b1110, cp[15:12]};
            s.b[1] = {2'b10, cp[11:6]};
            s.b[2] = {2'b10, cp[5:0]};
            s.n    = 3'd3;
        end
        else
        begin
            s.b[0] = {5'b11110, cp[20:18]};
            s.b[1] = {2'b10, cp[17:12]};
            s.b[2] = {2'b10, cp[11:6]};
            s.b[3] = {2'b10, cp[5:0]};
            s.n    = 3'd4;
        end
        if (!en)
        begin
            s.n = 3'd0;
        end
        return s;
    endfunction

endpackage

/* src/t2u_expand.sv */
`timescale 1ns / 1ps

module t2u_expand
    import t2u_pkg::*;
(
    input  logic [2:0]  mode,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  t2u_state_t  st,
    output t2u_state_t  st_next,
    output t2u_expand_t res
);

    logic [15:0] unit;
    logic        unit_high;
    logic        unit_low;
    logic [20:0] cp1;
    logic [20:0] cp2;
    logic        v1;
    logic        v2;
    logic        raw;
    utf8_seq_t   e1;
    utf8_seq_t   e2;
    logic [2:0]  d;

    assign unit      = (mode == MODE_UTF16LE) ? {in_byte, st.held_byte}
                                              : {st.held_byte, in_byte};
    assign unit_high = (unit[15:10] == 6'b110110);
    assign unit_low  = (unit[15:10] == 6'b110111);

    always_comb
    begin
        st_next = st;
        cp1     = '0;
        cp2     = {5'd0, unit};
        v1      = 1'b0;
        v2      = 1'b0;
        raw     = 1'b0;
        case (mode)
            MODE_UTF16LE, MODE_UTF16BE:
            begin
                if (!st.held_valid)
                begin
                    st_next.held_byte  = in_byte;
                    st_next.held_valid = 1'b1;
                    v1  = in_last && st.pend_valid;
                    cp1 = {5'd0, st.pend_unit};
                end
                else
                begin
                    st_next.held_byte  = '0;
                    st_next.held_valid = 1'b0;
                    st_next.pend_unit  = '0;
                    st_next.pend_valid = 1'b0;
                    if (st.pend_valid && unit_low)
                    begin
                        v1  = 1'b1;
                        cp1 = 21'h10000 + {1'b0, st.pend_unit[9:0], unit[9:0]};
                    end
                    else
                    begin
                        v1  = st.pend_valid;
                        cp1 = {5'd0, st.pend_unit};
                        // a high surrogate waits for its partner unless the stream ends
                        v2  = !unit_high || in_last;
                        if (unit_high)
                        begin
                            st_next.pend_unit  = unit;
                            st_next.pend_valid = 1'b1;
                        end
                    end
                end
            end
            MODE_CP1252:
            begin
                v1 = 1'b1;
                if (in_byte[7:5] == 3'b100)
                begin
                    cp1 = {5'd0, cp1252_high(in_byte[4:0])};
                end
                else
                begin
                    cp1 = {13'd0, in_byte};
                end
            end
            MODE_LATIN1:
            begin
                v1  = 1'b1;
                cp1 = {13'd0, in_byte};
            end
            default:
            begin
                raw = 1'b1;
            end
        endcase
        if (in_last)
        begin
            st_next = '0;
        end
    end

    always_comb
    begin
        e1 = utf8_encode(cp1, v1);
        e2 = utf8_encode(cp2, v2);
        if (raw)
        begin
            e1      = '0;
            e1.b[0] = in_byte;
            e1.n    = 3'd1;
        end
        res       = '0;
        res.count = e1.n + e2.n;
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            d = 3'(k) - e1.n;
            if (3'(k) < e1.n)
            begin
                res.bytes[k] = e1.b[2'(k)];
            end
            else if (d < 3'd4)
            begin
                res.bytes[k] = e2.b[d[1:0]];
            end
            else
            begin
                res.bytes[k] = 8'h00;
            end
        end
    end

endmodule

/* src/text_to_utf8_transcoder.sv */
`timescale 1ns / 1ps
// Channel   Dir  Transaction carries
// s_axis    in   tdata[7:0] in_byte, tlast in_last
// m_axis    out  tdata[7:0] out_byte, tuser[0] has_byte, tuser[1] stream_end, tlast run_last
// cfg       in   cfg_wdata[2:0] conversion_mode, written when cfg_we is high
//
// One result transaction per cycle at best; an item producing n results (n = 0 to 6,
// or one bare end marker) holds the output buffer until all its results are taken.
// An item passes through the input register, then loads into the output buffer once it is free.
// The input register takes a new item while the buffer still drains its last result.
// rst_n is asynchronous: held byte, pending surrogate and mode return to zero.
// m_axis stalls hold the buffer; s_axis tready drops while the input register is full and cannot load.

module text_to_utf8_transcoder
    import t2u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,      // conversion_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] has_byte, [1] stream_end
    output logic       m_axis_tlast
);

    logic [2:0]                mode_reg;
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [7:0]                in_byte_reg;
    logic                      in_last_reg;
    t2u_state_t                state_reg;
    t2u_state_t                state_next;
    t2u_expand_t               exp_res;
    logic [MAX_BYTES-1:0][7:0] buf_byte_reg;
    logic [MAX_BYTES-1:0][7:0] buf_byte_next;
    logic [2:0]                buf_cnt_reg;
    logic [2:0]                buf_cnt_next;
    logic                      buf_end_reg;
    logic                      buf_end_next;
    logic                      buf_bare_reg;
    logic                      buf_bare_next;
    logic                      load;
    logic                      out_take;

    t2u_expand u_expand (
        .mode    (mode_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (exp_res)
    );

    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign load          = in_valid_reg &&
                           ((buf_cnt_reg == 3'd0) || ((buf_cnt_reg == 3'd1) && m_axis_tready));
    assign s_axis_tready = !in_valid_reg || load;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    always_comb
    begin
        buf_byte_next = buf_byte_reg;
        buf_cnt_next  = buf_cnt_reg;
        buf_end_next  = buf_end_reg;
        buf_bare_next = buf_bare_reg;
        if (load)
        begin
            buf_end_next = in_last_reg;
            if ((exp_res.count == 3'd0) && in_last_reg)
            begin
                buf_byte_next = '0;
                buf_cnt_next  = 3'd1;
                buf_bare_next = 1'b1;
            end
            else
            begin
                buf_byte_next = exp_res.bytes;
                buf_cnt_next  = exp_res.count;
                buf_bare_next = 1'b0;
            end
        end
        else if (out_take)
        begin
            buf_byte_next = buf_byte_reg >> 8;
            buf_cnt_next  = buf_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_PASS;
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            buf_cnt_reg  <= 3'd0;
            buf_end_reg  <= 1'b0;
            buf_bare_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            if (load)
            begin
                state_reg <= state_next;
            end
            buf_cnt_reg  <= buf_cnt_next;
            buf_end_reg  <= buf_end_next;
            buf_bare_reg <= buf_bare_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        buf_byte_reg <= buf_byte_next;
    end

    assign m_axis_tvalid   = (buf_cnt_reg != 3'd0);
    assign m_axis_tdata    = buf_byte_reg[0];
    assign m_axis_tlast    = (buf_cnt_reg == 3'd1);
    assign m_axis_tuser[0] = !buf_bare_reg;
    assign m_axis_tuser[1] = buf_end_reg && (buf_cnt_reg == 3'd1);

    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= 3'(MAX_BYTES))
        else $error("output buffer count out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (buf_cnt_reg == 3'd0) || ((buf_cnt_reg == 3'd1) && m_axis_tready))
        else $error("buffer reloaded while results remain");

    a_bare_single: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_bare_reg && (buf_cnt_reg != 3'd0)) |-> (buf_cnt_reg == 3'd1))
        else $error("bare end marker with more than one result");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (load && in_last_reg) |=> !state_reg.held_valid && !state_reg.pend_valid)
        else $error("state not cleared after end of stream");

endmodule

/* test/text_to_utf8_transcoder_tb.sv */
`timescale 1ns / 1ps

import t2u_pkg::*;

// Windows-1252 code points for bytes 0x80 to 0x9F
localparam logic [0:31][15:0] WIN1252_HIGH = {
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
};

typedef struct {
    logic [7:0] value;
    logic       has_byte;
    logic       run_last;
    logic       stream_end;
} utf8_result_t;

class utf8_scoreboard;
    logic [2:0]   mode;
    logic [7:0]   held_byte;
    logic         held_valid;
    logic [15:0]  pend_unit;
    logic         pend_valid;
    logic [7:0]   step_bytes[$];
    utf8_result_t expected_q[$];
    int           errors;

    function new();
        mode = MODE_PASS;
        errors = 0;
        clear_state();
    endfunction

    function void clear_state();
        held_byte = '0;
        held_valid = 1'b0;
        pend_unit = '0;
        pend_valid = 1'b0;
    endfunction

    function void put_point(int unsigned cp);
        if (cp < 'h80)
        begin
            step_bytes.push_back(8'(cp));
        end
        else if (cp < 'h800)
        begin
            step_bytes.push_back(8'(8'hC0 | (cp >> 6)));
            step_bytes.push_back(8'(8'h80 | (cp & 'h3F)));
        end
        else if (cp < 'h10000)
        begin
            step_bytes.push_back(8'(8'hE0 | (cp >> 12)));
            step_bytes.push_back(8'(8'h80 | ((cp >> 6) & 'h3F)));
            step_bytes.push_back(8'(8'h80 | (cp & 'h3F)));
        end
        else if (cp < 'h110000)
        begin
            step_bytes.push_back(8'(8'hF0 | (cp >> 18)));
            step_bytes.push_back(8'(8'h80 | ((cp >> 12) & 'h3F)));
            step_bytes.push_back(8'(8'h80 | ((cp >> 6) & 'h3F)));
            step_bytes.push_back(8'(8'h80 | (cp & 'h3F)));
        end
    endfunction

    function void take_unit(logic [15:0] unit);
        int unsigned cp;
        if (pend_valid)
        begin
            if (unit >= 16'hDC00 && unit <= 16'hDFFF)
            begin
                cp = 32'h10000 + ((32'(pend_unit) - 32'hD800) << 10)
                   + (32'(unit) - 32'hDC00);
                pend_valid = 1'b0;
                pend_unit = '0;
                put_point(cp);
                return;
            end
            put_point(32'(pend_unit));
            pend_valid = 1'b0;
            pend_unit = '0;
        end
        if (unit >= 16'hD800 && unit <= 16'hDBFF)
        begin
            pend_unit = unit;
            pend_valid = 1'b1;
        end
        else
        begin
            put_point(32'(unit));
        end
    endfunction

    function void note_input(logic [7:0] b, logic last);
        utf8_result_t r;
        step_bytes.delete();
        case (mode)
            MODE_UTF16LE, MODE_UTF16BE:
            begin
                if (!held_valid)
                begin
                    held_byte = b;
                    held_valid = 1'b1;
                end
                else
                begin
                    held_valid = 1'b0;
                    if (mode == MODE_UTF16LE)
                        take_unit({b, held_byte});
                    else
                        take_unit({held_byte, b});
                    held_byte = '0;
                end
                if (last && pend_valid)
                    put_point(32'(pend_unit));
            end
            MODE_CP1252:
            begin
                if (b >= 8'h80 && b <= 8'h9F)
                    put_point(32'(WIN1252_HIGH[b[4:0]]));
                else
                    put_point(32'(b));
            end
            MODE_LATIN1:
                put_point(32'(b));
            default:
                step_bytes.push_back(b);
        endcase
        if (last)
            clear_state();
        if (step_bytes.size() == 0)
        begin
            if (last)
            begin
                r.value = 8'h00;
                r.has_byte = 1'b0;
                r.run_last = 1'b1;
                r.stream_end = 1'b1;
                expected_q.push_back(r);
            end
        end
        else
        begin
            foreach (step_bytes[k])
            begin
                r.value = step_bytes[k];
                r.has_byte = 1'b1;
                r.run_last = (k == step_bytes.size() - 1);
                r.stream_end = r.run_last && last;
                expected_q.push_back(r);
            end
        end
    endfunction

    function void check_result(logic [7:0] data, logic has_byte, logic stream_end,
                               logic run_last);
        utf8_result_t e;
        if (expected_q.size() == 0)
        begin
            $error("unexpected transaction: out_byte %h has_byte %b", data, has_byte);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (data !== e.value)
        begin
            $error("out_byte: expected %h, got %h", e.value, data);
            errors++;
        end
        if (has_byte !== e.has_byte)
        begin
            $error("has_byte: expected %b, got %b", e.has_byte, has_byte);
            errors++;
        end
        if (run_last !== e.run_last)
        begin
            $error("run_last: expected %b, got %b", e.run_last, run_last);
            errors++;
        end
        if (stream_end !== e.stream_end)
        begin
            $error("stream_end: expected %b, got %b", e.stream_end, stream_end);
            errors++;
        end
    endfunction
endclass

module text_to_utf8_transcoder_tb;

    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 24;
    localparam int HOLD_CYCLES   = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_wdata = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    utf8_scoreboard sb;
    int send_idle_pct = 34;
    int recv_idle_pct = 79;
    int hold_left = 0;
    int quiet_cycles = 0;
    int items_sent = 0;

    text_to_utf8_transcoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // called and returns at a falling edge; tvalid stays high for back-to-back transactions
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_unit(input logic [15:0] u, input logic end_on);
        if (sb.mode == MODE_UTF16BE)
        begin
            send_byte(u[15:8], 1'b0);
            send_byte(u[7:0], end_on);
        end
        else
        begin
            send_byte(u[7:0], 1'b0);
            send_byte(u[15:8], end_on);
        end
    endtask

    // units with no result may still be in flight once the queue is empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic [2:0] m);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    task automatic utf16_burst();
        int unsigned pick;
        logic        end_now;
        logic [15:0] u;
        pick = $urandom_range(99);
        end_now = ($urandom_range(7) == 0);
        if (pick < 40)
        begin
            if ($urandom_range(2) == 0)
                u = 16'($urandom);
            else
                u = 16'($urandom_range(16'h07FF));
            if (u[15:11] == 5'b11011)
                u[15] = 1'b0;
            send_unit(u, end_now);
        end
        else if (pick < 70)
        begin
            send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), 1'b0);
            send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), end_now);
        end
        else if (pick < 80)
        begin
            send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)), end_now);
        end
        else if (pick < 88)
        begin
            send_unit(16'($urandom_range(16'hDBFF, 16'hD800)), end_now);
        end
        else if (pick < 94)
        begin
            send_byte(8'($urandom), 1'b1);
        end
        else
        begin
            send_byte(8'($urandom), end_now);
        end
    endtask

    task automatic byte_burst();
        logic [7:0] b;
        if (sb.mode == MODE_CP1252 && $urandom_range(1) == 0)
            b = 8'($urandom_range(8'h9F, 8'h80));
        else
            b = 8'($urandom);
        send_byte(b, $urandom_range(9) == 0);
    endtask

    initial
    begin
        logic [2:0] phase_modes [PHASES];
        int         target;
        phase_modes = '{MODE_UTF16LE, MODE_CP1252, MODE_UTF16BE, MODE_SPARE7,
                        MODE_LATIN1, MODE_UTF16LE, MODE_PASS, MODE_SPARE5,
                        MODE_UTF16BE, MODE_UTF16LE, MODE_SPARE6, MODE_CP1252};
        sb = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset mode is passthrough
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();
        write_mode(MODE_LATIN1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();
        write_mode(MODE_CP1252);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hA0, 1'b1);
        wait_idle();
        write_mode(MODE_UTF16LE);
        send_unit(16'hD83D, 1'b0);
        send_unit(16'hDE00, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hDBFF, 1'b1);
        send_byte(8'h41, 1'b1);
        wait_idle();
        write_mode(MODE_UTF16BE);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            if (p < 4)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 79;
            end
            else if (p < 8)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_mode(phase_modes[p]);
            if (p == 9)
                hold_left = HOLD_CYCLES;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if (sb.mode == MODE_UTF16LE || sb.mode == MODE_UTF16BE)
                    utf16_burst();
                else
                    byte_burst();
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
